// ----- hw/rtl/line_follower_mode_controller_assert.svh -----
// Assertion macros for the line follower mode controller.
`ifndef LINE_FOLLOWER_MODE_CONTROLLER_ASSERT_SVH
`define LINE_FOLLOWER_MODE_CONTROLLER_ASSERT_SVH

// Checked only while out of reset.
`define LFMC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define LFMC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/lfmc_pkg.sv -----
// Shared types, codes and helpers for the line follower mode controller.
package lfmc_pkg;

   localparam int BUMPER_W     = 6;
   localparam int DUTY_W       = 7;
   localparam int BLINK_W      = 8;
   localparam int LOST_W       = 10;
   localparam int HARD_W       = 3;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 10;
   localparam int RSP_DATA_W   = 32;

   localparam logic [DUTY_W-1:0]  DUTY_MAX          = 7'd100;
   localparam logic [DUTY_W-1:0]  BASE_DUTY_RESET   = 7'd25;
   localparam logic [DUTY_W-1:0]  DUTY_BOOST_RESET  = 7'd10;
   localparam logic [BLINK_W-1:0] BLINK_TICKS_RESET = 8'd50;
   localparam logic [LOST_W-1:0]  LOST_LIMIT_RESET  = 10'd1000;
   localparam logic [HARD_W-1:0]  HARD_TURN_RESET   = 3'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_DUTY   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DUTY_BOOST  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_TICKS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOST_LIMIT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HARD_TURN   = 3'd4;

   typedef enum logic [2:0] {
      SKEW_SLIGHT_LEFT  = 3'd0,
      SKEW_SLIGHT_RIGHT = 3'd1,
      SKEW_HARD_LEFT    = 3'd2,
      SKEW_HARD_RIGHT   = 3'd3,
      SKEW_CENTERED     = 3'd4,
      SKEW_NO_TRACK     = 3'd5
   } skew_type;

   typedef enum logic [2:0] {
      COLOR_RED    = 3'd0,
      COLOR_YELLOW = 3'd1,
      COLOR_GREEN  = 3'd2,
      COLOR_CYAN   = 3'd3,
      COLOR_BLUE   = 3'd4,
      COLOR_WHITE  = 3'd5,
      COLOR_OFF    = 3'd6
   } color_type;

   typedef struct packed {
      skew_type  skew;
      color_type color;
   } class_type;

   // Listed high to low, so skew_code lands in the lowest bits of tdata.
   typedef struct packed {
      logic              tracking_mode;
      logic              front_lamps;
      logic [DUTY_W-1:0] right_duty;
      logic [DUTY_W-1:0] left_duty;
      logic              right_reverse;
      logic              left_reverse;
      logic              motors_enabled;
      logic              status_led;
      color_type         color_code;
      skew_type          skew_code;
   } rsp_type;

   function automatic logic [DUTY_W-1:0] cap_duty(input logic [DUTY_W:0] value);
      cap_duty = (value > {1'b0, DUTY_MAX}) ? DUTY_MAX : value[DUTY_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/lfmc_classify.sv -----
// Sensor skew classifier: half counts, skew code and LED color.
module lfmc_classify #(
   parameter int SENSOR_COUNT = 8
) (
   input  logic [SENSOR_COUNT-1:0]    sensor_bits,
   input  logic [lfmc_pkg::HARD_W-1:0] hard_turn_count,
   output lfmc_pkg::class_type        result
);

   localparam int RIGHT_N = SENSOR_COUNT / 2;
   localparam int LEFT_N  = SENSOR_COUNT - RIGHT_N;
   localparam int CNT_W   = $clog2(LEFT_N + 1);
   localparam int CMP_W   = (CNT_W > lfmc_pkg::HARD_W) ? CNT_W : lfmc_pkg::HARD_W;

   logic [CNT_W-1:0] right_cnt;
   logic [CNT_W-1:0] left_cnt;

   always_comb begin
      right_cnt = '0;
      left_cnt  = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (i < RIGHT_N) begin
            right_cnt = right_cnt + CNT_W'(sensor_bits[i]);
         end else begin
            left_cnt = left_cnt + CNT_W'(sensor_bits[i]);
         end
      end
   end

   always_comb begin
      if (left_cnt == '0 && right_cnt == '0) begin
         result = '{skew: lfmc_pkg::SKEW_NO_TRACK, color: lfmc_pkg::COLOR_WHITE};
      end else if (right_cnt == '0) begin
         result = '{skew: lfmc_pkg::SKEW_HARD_LEFT, color: lfmc_pkg::COLOR_RED};
      end else if (left_cnt == '0 || CMP_W'(right_cnt) >= CMP_W'(hard_turn_count)) begin
         result = '{skew: lfmc_pkg::SKEW_HARD_RIGHT, color: lfmc_pkg::COLOR_BLUE};
      end else if (left_cnt > right_cnt) begin
         result = '{skew: lfmc_pkg::SKEW_SLIGHT_LEFT, color: lfmc_pkg::COLOR_YELLOW};
      end else if (left_cnt < right_cnt) begin
         result = '{skew: lfmc_pkg::SKEW_SLIGHT_RIGHT, color: lfmc_pkg::COLOR_CYAN};
      end else begin
         result = '{skew: lfmc_pkg::SKEW_CENTERED, color: lfmc_pkg::COLOR_GREEN};
      end
   end

endmodule

// ----- hw/rtl/line_follower_mode_controller.sv -----
// Top level of the line follower mode controller: input stage, state update, result stage.
//
//  channel  direction  payload
//  req_*    in         tuser: mode; tdata: sensor_bits, bumper_bits (low bits first)
//  rsp_*    out        tdata: skew_code .. tracking_mode, 26 bits in 32
//  csr_*    in         csr_index selects register, csr_wdata holds the value
//
// One transaction per cycle unless rsp stalls; req passes the input, then the result register.
// The robot state updates as an item moves from the input register into
// the result register, so the next item always sees the updated state.
// A stalled rsp holds its result; one more req is taken into the input stage.
// Synchronous reset returns valids, robot state and configuration registers to defaults.
`include "line_follower_mode_controller_assert.svh"

module line_follower_mode_controller #(
   parameter int SENSOR_COUNT = 8
) (
   input  logic clock,
   input  logic reset,

   input  logic req_tvalid,
   output logic req_tready,
   input  logic req_tuser,                                          // mode
   input  logic [((SENSOR_COUNT + 6 + 7) / 8) * 8 - 1:0] req_tdata, // sensor_bits, bumper_bits

   output logic rsp_tvalid,
   input  logic rsp_tready,
   // skew_code, color_code, status_led, motors_enabled, left_reverse,
   // right_reverse, left_duty, right_duty, front_lamps, tracking_mode
   output logic [lfmc_pkg::RSP_DATA_W-1:0] rsp_tdata,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lfmc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lfmc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DUTY_W  = lfmc_pkg::DUTY_W;
   localparam int BLINK_W = lfmc_pkg::BLINK_W;
   localparam int LOST_W  = lfmc_pkg::LOST_W;
   localparam int RSP_W   = $bits(lfmc_pkg::rsp_type);

   // configuration registers
   logic [DUTY_W-1:0]           base_duty_ff;
   logic [DUTY_W-1:0]           duty_boost_ff;
   logic [BLINK_W-1:0]          blink_ticks_ff;
   logic [LOST_W-1:0]           lost_limit_ff;
   logic [lfmc_pkg::HARD_W-1:0] hard_turn_ff;

   // input stage
   logic                          in_valid_ff, in_valid_in;
   logic                          in_mode_ff;
   logic [SENSOR_COUNT-1:0]       in_sensor_ff;
   logic [lfmc_pkg::BUMPER_W-1:0] in_bumper_ff;

   // robot state
   logic run_mode_ff, run_mode_in;
   logic button_ff, button_in;
   logic [BLINK_W-1:0] blink_ff, blink_in;
   logic [LOST_W-1:0]  lost_ff, lost_in;
   logic led_ff, led_in;
   logic motors_ff, motors_in;
   logic left_dir_ff, left_dir_in;
   logic right_dir_ff, right_dir_in;
   logic [DUTY_W-1:0] left_duty_ff, left_duty_in;
   logic [DUTY_W-1:0] right_duty_ff, right_duty_in;

   // result stage
   logic              rsp_valid_ff, rsp_valid_in;
   lfmc_pkg::rsp_type rsp_ff, rsp_in;

   logic                advance;
   logic                req_fire;
   lfmc_pkg::class_type cls;
   logic [DUTY_W-1:0]   duty_lo;
   logic [DUTY_W-1:0]   duty_hi;
   logic [BLINK_W-1:0]  blink_inc;
   logic [LOST_W-1:0]   lost_inc;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(lfmc_pkg::RSP_DATA_W - RSP_W){1'b0}}, rsp_ff};

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   lfmc_classify #(
      .SENSOR_COUNT(SENSOR_COUNT)
   ) u_classify (
      .sensor_bits    (in_sensor_ff),
      .hard_turn_count(hard_turn_ff),
      .result         (cls)
   );

   assign duty_lo   = lfmc_pkg::cap_duty({1'b0, base_duty_ff});
   assign duty_hi   = lfmc_pkg::cap_duty({1'b0, duty_lo} + {1'b0, duty_boost_ff});
   assign blink_inc = blink_ff + 1'b1;
   assign lost_inc  = lost_ff + 1'b1;

   always_comb begin
      run_mode_in   = run_mode_ff;
      button_in     = button_ff;
      blink_in      = blink_ff;
      lost_in       = lost_ff;
      led_in        = led_ff;
      motors_in     = motors_ff;
      left_dir_in   = left_dir_ff;
      right_dir_in  = right_dir_ff;
      left_duty_in  = left_duty_ff;
      right_duty_in = right_duty_ff;

      if (!in_mode_ff) begin
         blink_in = blink_inc;
         if (!run_mode_ff) begin
            motors_in = 1'b0;
            if (cls.skew != lfmc_pkg::SKEW_NO_TRACK) begin
               if (blink_inc == blink_ticks_ff) begin
                  led_in   = !led_ff;
                  blink_in = '0;
               end
            end else begin
               led_in = 1'b0;
            end
         end else begin
            motors_in     = 1'b1;
            left_dir_in   = 1'b0;
            right_dir_in  = 1'b0;
            left_duty_in  = duty_lo;
            right_duty_in = duty_lo;
            case (cls.skew)
               lfmc_pkg::SKEW_SLIGHT_LEFT:  right_duty_in = duty_hi;
               lfmc_pkg::SKEW_SLIGHT_RIGHT: left_duty_in  = duty_hi;
               lfmc_pkg::SKEW_HARD_LEFT:    left_dir_in   = 1'b1;
               lfmc_pkg::SKEW_HARD_RIGHT:   right_dir_in  = 1'b1;
               default: ;
            endcase
            if (cls.skew == lfmc_pkg::SKEW_NO_TRACK) begin
               led_in  = 1'b0;
               lost_in = lost_inc;
               if (lost_inc == lost_limit_ff) begin
                  lost_in     = '0;
                  run_mode_in = 1'b0;
               end
            end else begin
               led_in  = 1'b1;
               lost_in = '0;
            end
         end
      end else begin
         // main button toggles, any other bumper drops to standby
         if (in_bumper_ff[0]) begin
            button_in   = !button_ff;
            run_mode_in = !button_ff;
         end else if (in_bumper_ff != '0) begin
            run_mode_in = 1'b0;
         end
      end

      rsp_in.skew_code      = in_mode_ff ? lfmc_pkg::SKEW_NO_TRACK : cls.skew;
      rsp_in.color_code     = in_mode_ff ? lfmc_pkg::COLOR_OFF : cls.color;
      rsp_in.status_led     = led_in;
      rsp_in.motors_enabled = motors_in;
      rsp_in.left_reverse   = left_dir_in;
      rsp_in.right_reverse  = right_dir_in;
      rsp_in.left_duty      = left_duty_in;
      rsp_in.right_duty     = right_duty_in;
      rsp_in.front_lamps    = motors_ff;
      rsp_in.tracking_mode  = run_mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_duty_ff   <= lfmc_pkg::BASE_DUTY_RESET;
         duty_boost_ff  <= lfmc_pkg::DUTY_BOOST_RESET;
         blink_ticks_ff <= lfmc_pkg::BLINK_TICKS_RESET;
         lost_limit_ff  <= lfmc_pkg::LOST_LIMIT_RESET;
         hard_turn_ff   <= lfmc_pkg::HARD_TURN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lfmc_pkg::CSR_BASE_DUTY:   base_duty_ff   <= csr_wdata[DUTY_W-1:0];
            lfmc_pkg::CSR_DUTY_BOOST:  duty_boost_ff  <= csr_wdata[DUTY_W-1:0];
            lfmc_pkg::CSR_BLINK_TICKS: blink_ticks_ff <= csr_wdata[BLINK_W-1:0];
            lfmc_pkg::CSR_LOST_LIMIT:  lost_limit_ff  <= csr_wdata[LOST_W-1:0];
            lfmc_pkg::CSR_HARD_TURN:   hard_turn_ff   <= csr_wdata[lfmc_pkg::HARD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         run_mode_ff   <= 1'b0;
         button_ff     <= 1'b0;
         blink_ff      <= '0;
         lost_ff       <= '0;
         led_ff        <= 1'b0;
         motors_ff     <= 1'b0;
         left_dir_ff   <= 1'b0;
         right_dir_ff  <= 1'b0;
         left_duty_ff  <= lfmc_pkg::BASE_DUTY_RESET;
         right_duty_ff <= lfmc_pkg::BASE_DUTY_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            run_mode_ff   <= run_mode_in;
            button_ff     <= button_in;
            blink_ff      <= blink_in;
            lost_ff       <= lost_in;
            led_ff        <= led_in;
            motors_ff     <= motors_in;
            left_dir_ff   <= left_dir_in;
            right_dir_ff  <= right_dir_in;
            left_duty_ff  <= left_duty_in;
            right_duty_ff <= right_duty_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_mode_ff   <= req_tuser;
         in_sensor_ff <= req_tdata[SENSOR_COUNT-1:0];
         in_bumper_ff <= req_tdata[SENSOR_COUNT +: lfmc_pkg::BUMPER_W];
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   `LFMC_ASSERT(a_track_tick_drives_motors, clock, reset,
      rsp_valid_ff && rsp_ff.color_code != lfmc_pkg::COLOR_OFF && rsp_ff.tracking_mode
         |-> rsp_ff.motors_enabled,
      "tracking tick result without motors enabled")
   `LFMC_ASSERT(a_no_track_color, clock, reset,
      rsp_valid_ff && rsp_ff.skew_code == lfmc_pkg::SKEW_NO_TRACK
         |-> rsp_ff.color_code == lfmc_pkg::COLOR_WHITE
             || rsp_ff.color_code == lfmc_pkg::COLOR_OFF,
      "no-track result with a track color")
   `LFMC_ASSERT_ALWAYS(a_duty_capped, clock,
      reset || (left_duty_ff <= lfmc_pkg::DUTY_MAX && right_duty_ff <= lfmc_pkg::DUTY_MAX),
      "wheel duty above full scale")

endmodule
